// ===== rtl/assert_macros.svh =====
// Assertion helpers; they expect clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond true at an edge implies prop at the same edge
`define ASSERT_IMPLY(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

// cond true at an edge implies prop at the next edge
`define ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

// ===== rtl/uvs_pkg.sv =====
`default_nettype none
package uvs_pkg;

  typedef enum logic [1:0] {
    CFG_RADIUS  = 2'd0,
    CFG_SECTORS = 2'd1,
    CFG_STACKS  = 2'd2
  } cfg_index_t;

  // quotient bits resolved per divider stage
  localparam int DIV_STEP = 4;
  // register stages of the sine unit
  localparam int SIN_STAGES = 10;

  // odd polynomial for sin(pi/2 * u), Q30
  localparam logic signed [31:0] SIN_COEF [7] = '{
    32'sd1686629713, -32'sd693598668, 32'sd85569306, -32'sd5026995,
    32'sd172272, -32'sd3864, 32'sd61
  };

  // divide by 2^sh, half away from zero
  function automatic logic signed [63:0] sround(input logic signed [63:0] v, input int sh);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    if (sh > 0) begin
      m = (m + (64'd1 << (sh - 1))) >> sh;
    end
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [15:0] clamp_q15(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) begin
      r = 16'sd32767;
    end else if (v < -64'sd32767) begin
      r = -16'sd32767;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // signed times unsigned, over 2^30, truncated toward zero
  function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                 input logic [30:0] b);
    logic [31:0] mag;
    logic [62:0] prod;
    logic [31:0] r;
    mag  = a[31] ? 32'(-a) : 32'(a);
    prod = 63'(mag) * 63'(b);
    r    = prod[61:30];
    return a[31] ? -$signed(r) : $signed(r);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/uvs_in_if.sv =====
`default_nettype none
interface uvs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stack_index;
  logic [7:0] sector_index;

  modport source(output valid, stack_index, sector_index, input ready);
  modport sink(input valid, stack_index, sector_index, output ready);
endinterface
`default_nettype wire

// ===== rtl/uvs_out_if.sv =====
`default_nettype none
interface uvs_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] pos_x;
  logic signed [16:0] pos_y;
  logic signed [16:0] pos_z;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic        [16:0] tex_u;
  logic        [16:0] tex_v;

  modport source(output valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                 tex_u, tex_v, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
               tex_u, tex_v, output ready);
endinterface
`default_nettype wire

// ===== rtl/uvs_div.sv =====
`default_nettype none
// Pipelined restoring divider by an 8-bit divisor, DIV_STEP quotient bits per stage.
// The divisor must hold still while items are in flight.
module uvs_div import uvs_pkg::*; #(
  parameter int W = 24,
  localparam int NS = (W + DIV_STEP - 1) / DIV_STEP,
  localparam int PW = NS * DIV_STEP
) (
  input  logic          clk,
  input  logic [NS-1:0] en,
  input  logic [W-1:0]  num,
  input  logic [7:0]    den,
  output logic [W-1:0]  quot
);

  logic [7:0]    rem_r [NS];
  logic [PW-1:0] num_r [NS];
  logic [PW-1:0] q_r   [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [7:0]    rem_in;
    logic [PW-1:0] num_in;
    logic [PW-1:0] q_in;
    logic [7:0]    rem_next;
    logic [PW-1:0] num_next;
    logic [PW-1:0] q_next;

    if (k == 0) begin : g_head
      assign rem_in = '0;
      assign num_in = PW'(num);
      assign q_in   = '0;
    end else begin : g_body
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign q_in   = q_r[k-1];
    end

    always_comb begin
      logic [8:0] t;
      rem_next = rem_in;
      num_next = num_in;
      q_next   = q_in;
      for (int s = 0; s < DIV_STEP; s++) begin
        t        = {rem_next, num_next[PW-1]};
        num_next = num_next << 1;
        if (t >= {1'b0, den}) begin
          rem_next = 8'(t - {1'b0, den});
          q_next   = {q_next[PW-2:0], 1'b1};
        end else begin
          rem_next = t[7:0];
          q_next   = {q_next[PW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k] <= rem_next;
        num_r[k] <= num_next;
        q_r[k]   <= q_next;
      end
    end
  end

  assign quot = q_r[NS-1][W-1:0];

endmodule
`default_nettype wire

// ===== rtl/uvs_sin.sv =====
`default_nettype none
// Pipelined sine of a phase fraction: quadrant fold, u^2, Horner over u^2, times u, round.
module uvs_sin import uvs_pkg::*; #(
  parameter int PHASE_BITS = 16,
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                        clk,
  input  logic [SIN_STAGES-1:0]       en,
  input  logic [PHASE_BITS-1:0]       phase,
  output logic signed [TRIG_FRAC_BITS:0] sin_val
);

  localparam int FB = PHASE_BITS - 2;
  localparam int US = 30 - FB;
  localparam int SH = 30 - TRIG_FRAC_BITS;
  localparam logic [31:0] MAXV = 32'((64'd1 << TRIG_FRAC_BITS) - 64'd1);

  logic [30:0]        u_r   [SIN_STAGES];
  logic [30:0]        u2_r  [SIN_STAGES];
  logic signed [31:0] acc_r [SIN_STAGES];
  logic               neg_r [SIN_STAGES];
  logic signed [TRIG_FRAC_BITS:0] out_r;

  // stage 0: fold to the first quadrant
  always_ff @(posedge clk) begin
    logic [30:0] ua;
    if (en[0]) begin
      ua = 31'(phase[FB-1:0]) << US;
      u_r[0]   <= phase[FB] ? 31'(31'h4000_0000 - ua) : ua;
      neg_r[0] <= phase[PHASE_BITS-1];
    end
  end

  // stage 1: u^2 in Q30
  always_ff @(posedge clk) begin
    logic [61:0] sq;
    if (en[1]) begin
      sq = 62'(u_r[0]) * 62'(u_r[0]);
      u_r[1]   <= u_r[0];
      u2_r[1]  <= sq[60:30];
      neg_r[1] <= neg_r[0];
    end
  end

  // stages 2..7: Horner steps, one multiply each
  for (genvar h = 0; h < 6; h++) begin : g_horner
    always_ff @(posedge clk) begin
      if (en[h+2]) begin
        if (h == 0) begin
          acc_r[h+2] <= SIN_COEF[5] + mul_q30(SIN_COEF[6], u2_r[1]);
        end else begin
          acc_r[h+2] <= SIN_COEF[5-h] + mul_q30(acc_r[h+1], u2_r[h+1]);
        end
        u_r[h+2]   <= u_r[h+1];
        u2_r[h+2]  <= u2_r[h+1];
        neg_r[h+2] <= neg_r[h+1];
      end
    end
  end

  // stage 8: times u
  always_ff @(posedge clk) begin
    if (en[8]) begin
      acc_r[8] <= mul_q30(acc_r[7], u_r[7]);
      neg_r[8] <= neg_r[7];
    end
  end

  // stage 9: clamp to [0, 1], round to output precision, apply sign
  always_ff @(posedge clk) begin
    logic [31:0] a;
    logic [31:0] m;
    if (en[9]) begin
      if (acc_r[8] < 0) begin
        a = '0;
      end else if (acc_r[8] > 32'sh4000_0000) begin
        a = 32'h4000_0000;
      end else begin
        a = 32'(acc_r[8]);
      end
      m = (a + ((32'd1 << SH) >> 1)) >> SH;
      if (m > MAXV) begin
        m = MAXV;
      end
      out_r <= neg_r[8] ? -$signed((TRIG_FRAC_BITS+1)'(m)) : $signed((TRIG_FRAC_BITS+1)'(m));
    end
  end

  assign sin_val = out_r;

endmodule
`default_nettype wire

// ===== rtl/uv_sphere_vertex_generator.sv =====
// UV sphere vertex generator: one grid point (stack, sector) in, one vertex out with
// Q9.8 position, Q1.15 normal and Q1.16 texture coordinates. Fully pipelined: a new
// item is taken every cycle unless backpressure has filled every stage. The path
// runs through the index/count dividers, the polynomial sine pipeline and two
// multiply stages. Backpressure stalls only the stages that hold data, so bubbles
// still fill. The user must write radius and counts through the cfg port only while
// no item is in flight; the block does not enforce this. A count of zero acts as one.
`default_nettype none
`include "assert_macros.svh"
module uv_sphere_vertex_generator import uvs_pkg::*; #(
  parameter int PHASE_BITS = 16,
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  uvs_in_if.sink          grid,
  uvs_out_if.source       vertex
);

  localparam int DIV_W  = 8 + ((PHASE_BITS > 16) ? PHASE_BITS : 16);
  localparam int DIV_ST = (DIV_W + DIV_STEP - 1) / DIV_STEP;
  localparam int PH_I   = DIV_ST + 1;
  localparam int A_I    = PH_I + 1 + SIN_STAGES;
  localparam int NSTG   = A_I + 2;
  localparam int TW     = TRIG_FRAC_BITS + 1;
  localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);

  logic [15:0] radius;
  logic [7:0]  sectors;
  logic [7:0]  stacks;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius  <= 16'd256;
      sectors <= 8'd16;
      stacks  <= 8'd8;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RADIUS:  radius  <= cfg_data;
        CFG_SECTORS: sectors <= (cfg_data[7:0] == 8'd0) ? 8'd1 : cfg_data[7:0];
        CFG_STACKS:  stacks  <= (cfg_data[7:0] == 8'd0) ? 8'd1 : cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // valid chain; a stage loads when it is empty or its successor moves
  logic [NSTG-1:0] valid;
  logic [NSTG-1:0] valid_in;
  logic [NSTG-1:0] en;

  assign valid_in = {valid[NSTG-2:0], grid.valid};

  always_comb begin
    en[NSTG-1] = !valid[NSTG-1] || vertex.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          valid[k] <= valid_in[k];
        end
      end
    end
  end

  assign grid.ready = en[0];

  // stage 0: saturate indices, form rounded numerators
  logic [DIV_W-1:0] num_tu, num_tv, num_sec, num_stk;

  always_ff @(posedge clk) begin
    logic [7:0] i_sat;
    logic [7:0] j_sat;
    if (en[0]) begin
      i_sat = (grid.stack_index > stacks) ? stacks : grid.stack_index;
      j_sat = (grid.sector_index > sectors) ? sectors : grid.sector_index;
      num_tu  <= (DIV_W'(j_sat) << 16) + DIV_W'(sectors >> 1);
      num_tv  <= (DIV_W'(i_sat) << 16) + DIV_W'(stacks >> 1);
      num_sec <= (DIV_W'(j_sat) << PHASE_BITS) + DIV_W'(sectors >> 1);
      num_stk <= (DIV_W'(i_sat) << (PHASE_BITS - 1)) + DIV_W'(stacks >> 1);
    end
  end

  logic [DIV_W-1:0] q_tu, q_tv, q_sec, q_stk;

  uvs_div #(.W(DIV_W)) u_div_tu (
    .clk(clk), .en(en[1 +: DIV_ST]), .num(num_tu), .den(sectors), .quot(q_tu));
  uvs_div #(.W(DIV_W)) u_div_tv (
    .clk(clk), .en(en[1 +: DIV_ST]), .num(num_tv), .den(stacks), .quot(q_tv));
  uvs_div #(.W(DIV_W)) u_div_sec (
    .clk(clk), .en(en[1 +: DIV_ST]), .num(num_sec), .den(sectors), .quot(q_sec));
  uvs_div #(.W(DIV_W)) u_div_stk (
    .clk(clk), .en(en[1 +: DIV_ST]), .num(num_stk), .den(stacks), .quot(q_stk));

  // phase stage: stack angle runs from a quarter turn down to minus a quarter turn
  logic [PHASE_BITS-1:0] ph_ss, ph_cs, ph_sc, ph_cc;
  logic [16:0] tu_s [SIN_STAGES+1];
  logic [16:0] tv_s [SIN_STAGES+1];

  always_ff @(posedge clk) begin
    logic [PHASE_BITS-1:0] stk;
    if (en[PH_I]) begin
      stk = QUARTER - q_stk[PHASE_BITS-1:0];
      ph_ss <= stk;
      ph_cs <= stk + QUARTER;
      ph_sc <= q_sec[PHASE_BITS-1:0];
      ph_cc <= q_sec[PHASE_BITS-1:0] + QUARTER;
      tu_s[0] <= q_tu[16:0];
      tv_s[0] <= q_tv[16:0];
    end
  end

  for (genvar k = 0; k < SIN_STAGES; k++) begin : g_tex
    always_ff @(posedge clk) begin
      if (en[PH_I+1+k]) begin
        tu_s[k+1] <= tu_s[k];
        tv_s[k+1] <= tv_s[k];
      end
    end
  end

  logic signed [TW-1:0] ss, cs, sc, cc;

  uvs_sin #(.PHASE_BITS(PHASE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sin_ss (
    .clk(clk), .en(en[PH_I+1 +: SIN_STAGES]), .phase(ph_ss), .sin_val(ss));
  uvs_sin #(.PHASE_BITS(PHASE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sin_cs (
    .clk(clk), .en(en[PH_I+1 +: SIN_STAGES]), .phase(ph_cs), .sin_val(cs));
  uvs_sin #(.PHASE_BITS(PHASE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sin_sc (
    .clk(clk), .en(en[PH_I+1 +: SIN_STAGES]), .phase(ph_sc), .sin_val(sc));
  uvs_sin #(.PHASE_BITS(PHASE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sin_cc (
    .clk(clk), .en(en[PH_I+1 +: SIN_STAGES]), .phase(ph_cc), .sin_val(cc));

  // stage A: ring radius, height, normals
  logic signed [16:0]   xz_a, py_a;
  logic signed [15:0]   nx_a, ny_a, nz_a;
  logic signed [TW-1:0] cc_a, sc_a;
  logic [16:0]          tu_a, tv_a;

  always_ff @(posedge clk) begin
    logic signed [63:0] r64;
    logic signed [63:0] cs64;
    logic signed [63:0] t;
    if (en[A_I]) begin
      r64  = 64'(signed'({1'b0, radius}));
      cs64 = 64'(cs);
      t    = sround(r64 * cs64, TRIG_FRAC_BITS);
      xz_a <= t[16:0];
      t    = sround(r64 * 64'(ss), TRIG_FRAC_BITS);
      py_a <= t[16:0];
      nx_a <= clamp_q15(sround(cs64 * 64'(cc), 2 * TRIG_FRAC_BITS - 15));
      nz_a <= clamp_q15(sround(cs64 * 64'(sc), 2 * TRIG_FRAC_BITS - 15));
      if (TRIG_FRAC_BITS >= 15) begin
        ny_a <= clamp_q15(sround(64'(ss), TRIG_FRAC_BITS - 15));
      end else begin
        ny_a <= clamp_q15(64'(ss) <<< (15 - TRIG_FRAC_BITS));
      end
      cc_a <= cc;
      sc_a <= sc;
      tu_a <= tu_s[SIN_STAGES];
      tv_a <= tv_s[SIN_STAGES];
    end
  end

  // stage B: x and z positions, output register
  logic signed [16:0] px_b, py_b, pz_b;
  logic signed [15:0] nx_b, ny_b, nz_b;
  logic [16:0]        tu_b, tv_b;

  always_ff @(posedge clk) begin
    logic signed [63:0] t;
    if (en[NSTG-1]) begin
      t    = sround(64'(xz_a) * 64'(cc_a), TRIG_FRAC_BITS);
      px_b <= t[16:0];
      t    = sround(64'(xz_a) * 64'(sc_a), TRIG_FRAC_BITS);
      pz_b <= t[16:0];
      py_b <= py_a;
      nx_b <= nx_a;
      ny_b <= ny_a;
      nz_b <= nz_a;
      tu_b <= tu_a;
      tv_b <= tv_a;
    end
  end

  assign vertex.valid    = valid[NSTG-1];
  assign vertex.pos_x    = px_b;
  assign vertex.pos_y    = py_b;
  assign vertex.pos_z    = pz_b;
  assign vertex.normal_x = nx_b;
  assign vertex.normal_y = ny_b;
  assign vertex.normal_z = nz_b;
  assign vertex.tex_u    = tu_b;
  assign vertex.tex_v    = tv_b;

  `ASSERT_IMPLY(a_ready_when_drained, !vertex.valid, grid.ready)
  `ASSERT_NEXT(a_accept_fills_entry, grid.valid && grid.ready, valid[0])
  `ASSERT_IMPLY(a_tex_in_range, vertex.valid,
                vertex.tex_u <= 17'd65536 && vertex.tex_v <= 17'd65536)
  `ASSERT_IMPLY(a_normal_clamped, vertex.valid,
                vertex.normal_x != 16'sh8000 && vertex.normal_z != 16'sh8000)
  `ASSERT_IMPLY(a_counts_nonzero, 1'b1, sectors != 8'd0 && stacks != 8'd0)

endmodule
`default_nettype wire

// ===== sim/uvs_tb_if.sv =====
`default_nettype none
// The block's channel interfaces (uvs_in_if, uvs_out_if) come with the RTL;
// this file only holds the vertex record that the checker queues up.
package uvs_tb_pkg;
  typedef struct packed {
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic        [16:0] tex_u;
    logic        [16:0] tex_v;
  } vertex_t;
endpackage
`default_nettype wire

// ===== sim/uv_sphere_vertex_generator_test.sv =====
`default_nettype none
module uv_sphere_vertex_generator_test;
  import uvs_pkg::*;
  import uvs_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PB = 16;
  localparam int TF = 15;
  localparam int LATENCY = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  uvs_in_if grid();
  uvs_out_if vertex();

  uv_sphere_vertex_generator u_top (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .grid(grid.sink), .vertex(vertex.source)
  );

  logic [15:0] radius_q88;
  logic [7:0] sectors_cfg;
  logic [7:0] stacks_cfg;
  vertex_t expected_vertices[$];
  int errors = 0;
  int vertices_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  localparam longint COEF [7] = '{1686629713, -693598668, 85569306, -5026995,
                                  172272, -3864, 61};

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("FAIL uv_sphere_vertex_generator");
    $finish;
  end

  function automatic longint round_away(longint v, int sh);
    longint m;
    m = v < 0 ? -v : v;
    if (sh > 0) m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint scale_q30(longint a, longint b);
    longint m;
    m = a < 0 ? -a : a;
    m = (m * b) >>> 30;
    return a < 0 ? -m : m;
  endfunction

  function automatic longint limit_mag(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint turn_sin(logic [PB-1:0] p);
    logic [1:0] quad;
    longint u, u2, acc;
    quad = p[PB-1:PB-2];
    u = longint'(p[PB-3:0]) <<< (30 - (PB - 2));
    if (quad[0]) u = (64'sd1 <<< 30) - u;
    u2 = (u * u) >>> 30;
    acc = COEF[6];
    for (int k = 5; k >= 0; k--) acc = COEF[k] + scale_q30(acc, u2);
    acc = scale_q30(acc, u);
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
    acc = round_away(acc, 30 - TF);
    if (acc > (64'sd1 <<< TF) - 1) acc = (64'sd1 <<< TF) - 1;
    return quad[1] ? -acc : acc;
  endfunction

  function automatic longint turn_cos(logic [PB-1:0] p);
    logic [PB-1:0] q;
    q = p + PB'(1 << (PB - 2));
    return turn_sin(q);
  endfunction

  function automatic vertex_t sphere_vertex(logic [7:0] stack_i, logic [7:0] sector_j);
    vertex_t v;
    longint nsec, nstk, i, j, cs, ss, cc, sc, xz;
    logic [PB-1:0] sec_ph, stk_ph;
    nsec = sectors_cfg == 8'd0 ? 64'sd1 : longint'(sectors_cfg);
    nstk = stacks_cfg == 8'd0 ? 64'sd1 : longint'(stacks_cfg);
    i = longint'(stack_i) > nstk ? nstk : longint'(stack_i);
    j = longint'(sector_j) > nsec ? nsec : longint'(sector_j);
    sec_ph = PB'(((j <<< PB) + nsec / 2) / nsec);
    stk_ph = PB'((64'sd1 <<< (PB - 2)) - (((i <<< (PB - 1)) + nstk / 2) / nstk));
    cs = turn_cos(stk_ph);
    ss = turn_sin(stk_ph);
    cc = turn_cos(sec_ph);
    sc = turn_sin(sec_ph);
    xz = round_away(longint'(radius_q88) * cs, TF);
    v.pos_y = 17'(round_away(longint'(radius_q88) * ss, TF));
    v.pos_x = 17'(round_away(xz * cc, TF));
    v.pos_z = 17'(round_away(xz * sc, TF));
    v.normal_x = 16'(limit_mag(round_away(cs * cc, 2 * TF - 15), 32767));
    v.normal_z = 16'(limit_mag(round_away(cs * sc, 2 * TF - 15), 32767));
    v.normal_y = 16'(limit_mag(round_away(ss, TF - 15), 32767));
    v.tex_u = 17'(((j <<< 16) + nsec / 2) / nsec);
    v.tex_v = 17'(((i <<< 16) + nstk / 2) / nstk);
    return v;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_RADIUS:  radius_q88 = value;
      CFG_SECTORS: sectors_cfg = value[7:0];
      CFG_STACKS:  stacks_cfg = value[7:0];
      default: ;
    endcase
  endtask

  // drain, then let the pipeline empty before touching registers
  task automatic settle();
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_sphere(logic [15:0] r, logic [7:0] ns, logic [7:0] nk);
    settle();
    write_reg(CFG_RADIUS, r);
    write_reg(CFG_SECTORS, {8'd0, ns});
    write_reg(CFG_STACKS, {8'd0, nk});
  endtask

  // entered and left just after a rising edge
  task automatic send_point(logic [7:0] stack_i, logic [7:0] sector_j);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      grid.valid <= 1'b0;
      @(posedge clk);
    end
    grid.valid <= 1'b1;
    grid.stack_index <= stack_i;
    grid.sector_index <= sector_j;
    do @(posedge clk); while (!grid.ready);
    expected_vertices.insert(expected_vertices.size(), sphere_vertex(stack_i, sector_j));
  endtask

  task automatic idle_input();
    grid.valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) vertex.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    vertex_t want;
    if (!rst && vertex.valid && vertex.ready) begin
      vertices_seen++;
      if (expected_vertices.size() == 0) begin
        report_mismatch("unexpected vertex", 0, 0);
      end else begin
        want = expected_vertices.pop_front();
        if (vertex.pos_x !== want.pos_x) report_mismatch("pos_x", vertex.pos_x, want.pos_x);
        if (vertex.pos_y !== want.pos_y) report_mismatch("pos_y", vertex.pos_y, want.pos_y);
        if (vertex.pos_z !== want.pos_z) report_mismatch("pos_z", vertex.pos_z, want.pos_z);
        if (vertex.normal_x !== want.normal_x)
          report_mismatch("normal_x", vertex.normal_x, want.normal_x);
        if (vertex.normal_y !== want.normal_y)
          report_mismatch("normal_y", vertex.normal_y, want.normal_y);
        if (vertex.normal_z !== want.normal_z)
          report_mismatch("normal_z", vertex.normal_z, want.normal_z);
        if (vertex.tex_u !== want.tex_u) report_mismatch("tex_u", vertex.tex_u, want.tex_u);
        if (vertex.tex_v !== want.tex_v) report_mismatch("tex_v", vertex.tex_v, want.tex_v);
      end
    end
  end

  task automatic test_reset_defaults();
    send_point(8'd0, 8'd0);
    send_point(8'd4, 8'd4);
    send_point(8'd8, 8'd16);
    send_point(8'd255, 8'd255);
    idle_input();
  endtask

  task automatic test_directed_extremes();
    set_sphere(16'hFFFF, 8'd255, 8'd255);
    send_point(8'd0, 8'd0);
    send_point(8'd127, 8'd64);
    send_point(8'd128, 8'd191);
    send_point(8'd255, 8'd255);
    send_point(8'd170, 8'd85);
    send_point(8'd85, 8'd170);
    idle_input();
    // counts of zero act as one; indices saturate
    set_sphere(16'd0, 8'd0, 8'd0);
    send_point(8'd0, 8'd0);
    send_point(8'd1, 8'd1);
    send_point(8'd200, 8'd77);
    idle_input();
    set_sphere(16'h0100, 8'd1, 8'd1);
    send_point(8'd0, 8'd1);
    send_point(8'd1, 8'd0);
    send_point(8'd255, 8'd255);
    idle_input();
    set_sphere(16'h8000, 8'd3, 8'd7);
    for (int k = 0; k < 8; k++) send_point(8'(k), 8'(k));
    idle_input();
  endtask

  task automatic random_points(int n);
    logic [7:0] a, b;
    for (int k = 0; k < n; k++) begin
      // mostly in-range grid points, some saturating ones
      if ($urandom_range(9, 0) < 8) begin
        a = 8'($urandom_range(stacks_cfg, 0));
        b = 8'($urandom_range(sectors_cfg, 0));
      end else begin
        a = 8'($urandom);
        b = 8'($urandom);
      end
      send_point(a, b);
    end
    idle_input();
  endtask

  task automatic test_random_phases();
    int send_pct [5] = '{0, 83, 0, 38, 0};
    int recv_pct [5] = '{0, 0, 83, 38, 0};
    for (int ph = 0; ph < 5; ph++) begin
      set_sphere(16'($urandom), 8'($urandom), 8'($urandom_range(40, 0)));
      send_idle_pct = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      random_points(125);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    grid.valid = 1'b0;
    grid.stack_index = '0;
    grid.sector_index = '0;
    vertex.ready = 1'b0;
    radius_q88 = 16'd256;
    sectors_cfg = 8'd16;
    stacks_cfg = 8'd8;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_extremes();
    test_random_phases();
    settle();
    $display("covered %0d vertices: default, extreme and random sphere settings,", vertices_seen);
    $display("zero counts, saturated indices, with and without handshake stalls");
    if (errors == 0) begin
      $display("PASS uv_sphere_vertex_generator");
    end else begin
      $display("FAIL uv_sphere_vertex_generator");
    end
    $finish;
  end
endmodule
`default_nettype wire
